// File: rtl/core/bss_pkg.sv
// Shared constants and types for the byte substring search block.
// No dependencies; imported by every module under rtl/core.

package bss_pkg;

   localparam int PAT_MAX    = 32;
   localparam int COUNT_BITS = 32;
   localparam int LEN_W      = $clog2(PAT_MAX + 1);
   localparam int CMP_W      = (COUNT_BITS > LEN_W) ? COUNT_BITS : LEN_W;
   localparam int OFFSET_W   = 32;

   localparam int REQ_DATA_W  = 8;
   localparam int REQ_USER_W  = 2;
   localparam int RSP_FIELD_W = 1 + OFFSET_W + 1;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   typedef enum logic [1:0] {
      MODE_START    = 2'd0,
      MODE_PATTERN  = 2'd1,
      MODE_HAYSTACK = 2'd2,
      MODE_END      = 2'd3
   } mode_type;

   // element PAT_MAX-1 is the newest byte
   typedef logic [PAT_MAX-1:0][7:0] window_type;

endpackage

// File: rtl/core/bss_compare.sv
// Lane-parallel compare of the haystack window against the right-aligned pattern.
// Depends on bss_pkg.

module bss_compare (
   input  bss_pkg::window_type          window_bytes,
   input  bss_pkg::window_type          pattern_bytes,
   input  logic [bss_pkg::PAT_MAX-1:0]  lane_mask,
   output logic                         hit
);
   import bss_pkg::*;

   logic [PAT_MAX-1:0] lane_ok;

   always_comb begin
      for (int j = 0; j < PAT_MAX; j++) begin
         lane_ok[j] = !lane_mask[j] || (window_bytes[j] == pattern_bytes[j]);
      end
      hit = &lane_ok;
   end

endmodule

// File: rtl/core/byte_substring_search.sv
// Top level of the byte substring search block.
// Depends on bss_pkg and bss_compare.
//
// Usage:
//   req channel: req_tuser carries the mode (start, pattern byte, haystack
//   byte, end), req_tdata the byte. A start transaction clears the pattern
//   and the search; pattern bytes append (beyond PAT_MAX they are dropped and
//   the overflow flag is set); haystack bytes shift into a PAT_MAX-byte
//   window that is compared lane by lane against the stored pattern, and the
//   first match offset is latched.
//   rsp channel: one transaction per end item with found, offset, overflow.
// Throughput: one req transaction per cycle, any mix of modes, save an end item
//   stalled as below; window shift, lane compare and counter update are combinational.
// Path: the result of an end item goes from the input register, where it is
//   accepted, to the output register that drives rsp.
// Stall: rsp has a one-entry output register. While it holds a result that is
//   not taken, a following end item waits in the input register and req_tready
//   drops; other items keep flowing until then.
// Reset: synchronous; clears the valid bits of both channel registers and the search
//   state but the pattern bytes, hidden by the cleared mask. No clearing pass is needed.

module byte_substring_search (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bss_pkg::REQ_DATA_W-1:0]  req_tdata,  // [7:0] data_byte
   input  logic [bss_pkg::REQ_USER_W-1:0]  req_tuser,  // [1:0] mode
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bss_pkg::RSP_DATA_W-1:0]  rsp_tdata   // [0] found, [32:1] match_offset,
                                                       // [33] pattern_overflow, rest zero
);
   import bss_pkg::*;

   // input register
   logic                      in_valid_ff, in_valid_in;
   mode_type                  in_mode_ff;
   logic [7:0]                in_byte_ff;

   // search state
   window_type                pat_ff, pat_in;
   logic [PAT_MAX-1:0]        mask_ff, mask_in;
   logic [LEN_W-1:0]          len_ff, len_in;
   window_type                win_ff, win_in;
   logic [COUNT_BITS-1:0]     count_ff, count_in;
   logic                      match_ff, match_in;
   logic [COUNT_BITS-1:0]     first_ff, first_in;
   logic                      ovf_ff, ovf_in;

   // output register
   logic                      out_valid_ff, out_valid_in;
   logic [RSP_DATA_W-1:0]     out_data_ff, out_data_in;

   logic                      stage_go;
   logic                      req_take;
   window_type                win_shift;
   logic                      hit;
   logic                      count_full;
   logic [COUNT_BITS-1:0]     count_inc;
   logic                      long_enough;
   logic                      found;
   logic [OFFSET_W-1:0]       offset;

   assign stage_go   = in_valid_ff && ((in_mode_ff != MODE_END) || !out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || stage_go;
   assign req_take   = req_tvalid && req_tready;
   assign in_valid_in = req_take || (in_valid_ff && !stage_go);

   assign win_shift   = {in_byte_ff, win_ff[PAT_MAX-1:1]};
   assign count_full  = &count_ff;
   assign count_inc   = count_ff + 1'b1;
   assign long_enough = CMP_W'(count_inc) >= CMP_W'(len_ff);

   bss_compare u_compare (
      .window_bytes  (win_shift),
      .pattern_bytes (pat_ff),
      .lane_mask     (mask_ff),
      .hit           (hit)
   );

   assign found  = (len_ff == '0) ? 1'b1 : match_ff;
   assign offset = (len_ff == '0 || !match_ff) ? '0 : OFFSET_W'(first_ff);

   always_comb begin
      pat_in       = pat_ff;
      mask_in      = mask_ff;
      len_in       = len_ff;
      win_in       = win_ff;
      count_in     = count_ff;
      match_in     = match_ff;
      first_in     = first_ff;
      ovf_in       = ovf_ff;
      out_data_in  = out_data_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      if (stage_go) begin
         case (in_mode_ff)
            MODE_START: begin
               mask_in  = '0;
               len_in   = '0;
               win_in   = '0;
               count_in = '0;
               match_in = 1'b0;
               first_in = '0;
               ovf_in   = 1'b0;
            end
            MODE_PATTERN: begin
               if (len_ff < LEN_W'(PAT_MAX)) begin
                  // pattern stays right-aligned to the window's newest byte
                  pat_in  = {in_byte_ff, pat_ff[PAT_MAX-1:1]};
                  mask_in = {1'b1, mask_ff[PAT_MAX-1:1]};
                  len_in  = len_ff + 1'b1;
               end else begin
                  ovf_in = 1'b1;
               end
            end
            MODE_HAYSTACK: begin
               win_in = win_shift;
               // a saturated counter keeps shifting but latches nothing new
               if (!count_full) begin
                  count_in = count_inc;
                  if (!match_ff && len_ff != '0 && long_enough && hit) begin
                     match_in = 1'b1;
                     first_in = COUNT_BITS'(CMP_W'(count_inc) - CMP_W'(len_ff));
                  end
               end
            end
            MODE_END: begin
               out_valid_in = 1'b1;
               out_data_in  = RSP_DATA_W'({ovf_ff, offset, found});
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mask_ff      <= '0;
         len_ff       <= '0;
         win_ff       <= '0;
         count_ff     <= '0;
         match_ff     <= 1'b0;
         first_ff     <= '0;
         ovf_ff       <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         mask_ff      <= mask_in;
         len_ff       <= len_in;
         win_ff       <= win_in;
         count_ff     <= count_in;
         match_ff     <= match_in;
         first_ff     <= first_in;
         ovf_ff       <= ovf_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_mode_ff <= mode_type'(req_tuser);
         in_byte_ff <= req_tdata[7:0];
      end
      pat_ff      <= pat_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

// File: rtl/core/bss_checker.sv
// Port-level assertions for byte_substring_search, attached by bind.
// Depends on bss_pkg.

module bss_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [bss_pkg::RSP_DATA_W-1:0]  rsp_tdata
);
   import bss_pkg::*;

   // stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transaction changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result present right after reset");

   // input only backs up behind a held result
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req stalled with an empty output register");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[RSP_DATA_W-1:RSP_FIELD_W] == '0)
      else $error("rsp padding bits not zero");

   a_offset_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[OFFSET_W:1] == '0)
      else $error("offset nonzero without a match");

endmodule

bind byte_substring_search bss_checker u_bss_checker (.*);
